### hdl/raster_to_block_tiler_with_edge_padding_unit_macros.svh
// Assertion macros used by the checker file of the tiler.
// The enclosing module must provide clk and arst_n.
`ifndef RASTER_TO_BLOCK_TILER_WITH_EDGE_PADDING_UNIT_MACROS_SVH
`define RASTER_TO_BLOCK_TILER_WITH_EDGE_PADDING_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define R2B_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define R2B_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/r2b_pkg.sv
`default_nettype none

package r2b_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int BLOCK_SIZE = 8;
	localparam int BLK_LOG = 3;
	localparam int PIX_W = 24;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam int WREG_W = 12;
	localparam int HREG_W = 16;
	localparam int ROWCNT_W = 4;
	localparam int BAND_W = 13;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

	// Request types.
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_ACCEPT = 2'd0;
	localparam logic [1:0] ST_REJECT = 2'd1;
	localparam logic [1:0] ST_PIXEL = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic       req_type;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  red_out;
		logic [7:0]  green_out;
		logic [7:0]  blue_out;
		logic [7:0]  block_column;
		logic [12:0] block_row;
		logic [5:0]  pixel_index;
		logic        last_of_block;
		logic        last_of_image;
	} rsp_t;

endpackage

`default_nettype wire

### hdl/r2b_stream_if.sv
`default_nettype none

interface r2b_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/r2b_band_store.sv
`default_nettype none

module r2b_band_store #(
	parameter int ADDR_W = 14
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [ADDR_W-1:0]         waddr,
	input  wire logic [r2b_pkg::PIX_W-1:0] wdata,
	input  wire logic                      re,
	input  wire logic [ADDR_W-1:0]         raddr,
	output      logic [r2b_pkg::PIX_W-1:0] rdata
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [r2b_pkg::PIX_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read data holds until the next read, so a stalled word keeps its pixel.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### hdl/r2b_ctrl.sv
`default_nettype none

module r2b_ctrl #(
	parameter int MAX_WIDTH = r2b_pkg::MAX_WIDTH_DEF,
	localparam int CW = $clog2(MAX_WIDTH),
	localparam int AW = r2b_pkg::BLK_LOG + CW
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [r2b_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [r2b_pkg::CFG_DATA_W-1:0] cfg_data,
	r2b_stream_if.sink                          req,
	output      logic                           mem_we,
	output      logic [AW-1:0]                  mem_waddr,
	output      logic [r2b_pkg::PIX_W-1:0]      mem_wdata,
	output      logic                           mem_re,
	output      logic [AW-1:0]                  mem_raddr,
	input  wire logic [r2b_pkg::PIX_W-1:0]      mem_rdata,
	output      logic                           res_valid,
	input  wire logic                           res_ready,
	output      r2b_pkg::rsp_t                  res_data
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int BLOCKS_MAX = (MAX_WIDTH + r2b_pkg::BLOCK_SIZE - 1) / r2b_pkg::BLOCK_SIZE;
	localparam int BKW = (BLOCKS_MAX > 1) ? $clog2(BLOCKS_MAX) : 1;
	localparam int XW = (BKW + 3 > CW + 1) ? BKW + 3 : CW + 1;
	localparam int RW = r2b_pkg::ROWCNT_W;
	localparam int HW = r2b_pkg::HREG_W;
	localparam int BDW = r2b_pkg::BAND_W;

	// Effective geometry, clamped when the register is written.
	logic [WW-1:0]    width_q;
	logic [BKW:0]     blocks_q;
	logic [HW-1:0]    height_q;

	logic [CW-1:0]    write_column_q;
	logic [HW-1:0]    write_row_q;
	logic             band_ready_q;
	logic [RW-1:0]    rows_q;
	logic [BKW-1:0]   drain_block_q;
	logic [5:0]       drain_pixel_q;
	logic [BDW-1:0]   drain_band_q;

	logic             valid_s1;
	logic [1:0]       status_s1;
	logic [7:0]       block_column_s1;
	logic [BDW-1:0]   block_row_s1;
	logic [5:0]       pixel_index_s1;
	logic             last_of_block_s1;
	logic             last_of_image_s1;

	logic             acc;
	logic             is_drain;
	logic             drain_go;
	logic [16:0]      wreg_ext;
	logic [16:0]      wclamp;
	logic [17:0]      blocks_sum;
	logic [WW-1:0]    width_m1;
	logic [CW:0]      wc_inc;
	logic [CW-1:0]    wr_col;
	logic             row_done;
	logic [RW-1:0]    rows_inc;
	logic [HW-1:0]    row_inc;
	logic             band_full;
	logic             drain_ok;
	logic [2:0]       rd_row;
	logic [2:0]       rd_y;
	logic [XW-1:0]    rd_x;
	logic [XW-1:0]    rd_xc;
	logic             final_band;
	logic             end_block;
	logic [BKW:0]     db_inc;
	logic             end_band;

	assign acc = req.valid && req.ready;
	assign is_drain = (req.data.req_type == r2b_pkg::REQ_DRAIN);
	assign drain_go = is_drain && drain_ok;
	assign req.ready = !valid_s1 || res_ready;

	// Width register: zero reads as one, anything past the store is the store width.
	always_comb begin
		wreg_ext = 17'(cfg_data[r2b_pkg::WREG_W-1:0]);
		if (wreg_ext == 17'd0) begin
			wclamp = 17'd1;
		end else if (wreg_ext > 17'(MAX_WIDTH)) begin
			wclamp = 17'(MAX_WIDTH);
		end else begin
			wclamp = wreg_ext;
		end
		blocks_sum = (18'(wclamp) + 18'(r2b_pkg::BLOCK_SIZE - 1)) >> r2b_pkg::BLK_LOG;
	end

	// Write side: clamp the column, then see whether the row completes.
	always_comb begin
		width_m1 = width_q - WW'(1);
		if ((CW+1)'(write_column_q) >= (CW+1)'(width_q)) begin
			wr_col = CW'(width_m1);
		end else begin
			wr_col = write_column_q;
		end
		wc_inc = (CW+1)'(write_column_q) + (CW+1)'(1);
		row_done = wc_inc >= (CW+1)'(width_q);
		rows_inc = rows_q + RW'(1);
		row_inc = write_row_q + HW'(1);
		band_full = (rows_inc >= RW'(r2b_pkg::BLOCK_SIZE)) || (row_inc >= height_q) ||
			(row_inc == '0);
	end

	// Drain side: clamp rows to the last stored row and columns to the last real one.
	always_comb begin
		drain_ok = band_ready_q && (rows_q != '0);
		rd_row = drain_pixel_q[5:3];
		if (RW'(rd_row) < rows_q) begin
			rd_y = rd_row;
		end else begin
			rd_y = 3'(rows_q - RW'(1));
		end
		rd_x = XW'({drain_block_q, drain_pixel_q[2:0]});
		if (rd_x >= XW'(width_q)) begin
			rd_xc = XW'(width_m1);
		end else begin
			rd_xc = rd_x;
		end
		final_band = (write_row_q >= height_q) || (write_row_q == '0);
		end_block = (drain_pixel_q == 6'd63);
		db_inc = (BKW+1)'(drain_block_q) + (BKW+1)'(1);
		end_band = end_block && (db_inc >= blocks_q);
	end

	always_comb begin
		mem_we = acc && !is_drain && !band_ready_q;
		mem_waddr = {rows_q[2:0], wr_col};
		mem_wdata = {req.data.red_in, req.data.green_in, req.data.blue_in};
		mem_re = acc && is_drain && drain_ok;
		mem_raddr = {rd_y, CW'(rd_xc)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WW'(r2b_pkg::BLOCK_SIZE);
			blocks_q <= (BKW+1)'(1);
			height_q <= HW'(r2b_pkg::BLOCK_SIZE);
			write_column_q <= '0;
			write_row_q <= '0;
			band_ready_q <= 1'b0;
			rows_q <= '0;
			drain_block_q <= '0;
			drain_pixel_q <= '0;
			drain_band_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					r2b_pkg::REG_WIDTH: begin
						width_q <= WW'(wclamp);
						blocks_q <= (BKW+1)'(blocks_sum);
					end
					r2b_pkg::REG_HEIGHT: begin
						height_q <= (cfg_data == '0) ? HW'(1) : cfg_data;
					end
					default: begin
					end
				endcase
			end
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (res_ready) begin
				valid_s1 <= 1'b0;
			end
			if (acc && !is_drain && !band_ready_q) begin
				if (row_done) begin
					write_column_q <= '0;
					rows_q <= rows_inc;
					write_row_q <= row_inc;
					band_ready_q <= band_full;
				end else begin
					write_column_q <= CW'(wc_inc);
				end
			end
			if (acc && is_drain && drain_ok) begin
				drain_pixel_q <= drain_pixel_q + 6'd1;
				if (end_band) begin
					drain_block_q <= '0;
					band_ready_q <= 1'b0;
					rows_q <= '0;
					if (final_band) begin
						write_row_q <= '0;
						write_column_q <= '0;
						drain_band_q <= '0;
					end else begin
						drain_band_q <= drain_band_q + BDW'(1);
					end
				end else if (end_block) begin
					drain_block_q <= BKW'(db_inc);
				end
			end
		end
	end

	// Only a drain that finds a ready band carries position fields; other words carry zeros.
	always_ff @(posedge clk) begin
		if (acc) begin
			if (!is_drain) begin
				status_s1 <= band_ready_q ? r2b_pkg::ST_REJECT : r2b_pkg::ST_ACCEPT;
			end else begin
				status_s1 <= drain_ok ? r2b_pkg::ST_PIXEL : r2b_pkg::ST_EMPTY;
			end
			block_column_s1 <= drain_go ? 8'(drain_block_q) : 8'd0;
			block_row_s1 <= drain_go ? drain_band_q : '0;
			pixel_index_s1 <= drain_go ? drain_pixel_q : 6'd0;
			last_of_block_s1 <= drain_go && end_block;
			last_of_image_s1 <= drain_go && end_band && final_band;
		end
	end

	assign res_valid = valid_s1;

	always_comb begin
		res_data.status = status_s1;
		res_data.red_out = '0;
		res_data.green_out = '0;
		res_data.blue_out = '0;
		if (status_s1 == r2b_pkg::ST_PIXEL) begin
			res_data.red_out = mem_rdata[23:16];
			res_data.green_out = mem_rdata[15:8];
			res_data.blue_out = mem_rdata[7:0];
		end
		res_data.block_column = block_column_s1;
		res_data.block_row = block_row_s1;
		res_data.pixel_index = pixel_index_s1;
		res_data.last_of_block = last_of_block_s1;
		res_data.last_of_image = last_of_image_s1;
	end

endmodule

`default_nettype wire

### hdl/r2b_out_buf.sv
`default_nettype none

module r2b_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output      logic          in_ready,
	input  wire r2b_pkg::rsp_t in_data,
	r2b_stream_if.source       rsp
);

	r2b_pkg::rsp_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign pop = rsp.valid && rsp.ready;
	assign rsp.valid = (count_q != 2'd0);
	assign rsp.data = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_data;
		end
	end

endmodule

`default_nettype wire

### hdl/raster_to_block_tiler_with_edge_padding_unit.sv
// Raster-to-8x8 block tiler with edge replication. Each request word is either a pixel write
// or a drain of one block pixel, and every request gives exactly one result word, which passes
// the result stage register and then the output buffer. One request is taken per clock unless
// the result stage and the output buffer are both full: a pixel write is a single store write
// and a drain is a single registered store read, so the one write port and one read port of
// the band store set the rate of one word per cycle. A two word output buffer keeps requests
// flowing while results wait; with the result side stalled, three requests are taken before
// the input stalls. The band store holds eight rows of MAX_WIDTH pixels and needs no clearing
// after reset. Writes to a full band come back rejected; drains with no ready band come back
// empty. Rows below the image and columns past the width repeat the last real row and column.
// The user must write configuration only while idle; the block does not enforce it.
`default_nettype none

module raster_to_block_tiler_with_edge_padding_unit #(
	parameter int MAX_WIDTH = r2b_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [r2b_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [r2b_pkg::CFG_DATA_W-1:0] cfg_data,
	r2b_stream_if.sink                          req,
	r2b_stream_if.source                        rsp
);

	localparam int AW = r2b_pkg::BLK_LOG + $clog2(MAX_WIDTH);

	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [r2b_pkg::PIX_W-1:0] mem_wdata;
	logic                      mem_re;
	logic [AW-1:0]             mem_raddr;
	logic [r2b_pkg::PIX_W-1:0] mem_rdata;
	logic                      res_valid;
	logic                      res_ready;
	r2b_pkg::rsp_t             res_data;

	r2b_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	r2b_band_store #(
		.ADDR_W(AW)
	) u_store (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	r2b_out_buf u_out (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(res_valid),
		.in_ready(res_ready),
		.in_data(res_data),
		.rsp(rsp)
	);

endmodule

`default_nettype wire

### hdl/r2b_checker.sv
`default_nettype none
`include "raster_to_block_tiler_with_edge_padding_unit_macros.svh"

module r2b_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire r2b_pkg::rsp_t rsp_data
);

	// Requests taken whose result word has not yet been delivered.
	logic [2:0] pend_q;
	logic       req_take;
	logic       rsp_take;
	logic       rsp_stall;
	logic       plain_word;
	logic       plain_zero;

	assign req_take = req_valid && req_ready;
	assign rsp_take = rsp_valid && rsp_ready;
	assign rsp_stall = rsp_valid && !rsp_ready;
	assign plain_word = rsp_valid && (rsp_data.status != r2b_pkg::ST_PIXEL);
	assign plain_zero = (rsp_data.red_out == 8'd0) && (rsp_data.block_row == 13'd0) &&
		(rsp_data.pixel_index == 6'd0) && !rsp_data.last_of_image;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
		end else begin
			pend_q <= pend_q + 3'(req_take) - 3'(rsp_take);
		end
	end

	`R2B_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_data), "stalled word changed")
	`R2B_ASSERT_IMP(a_no_invent, rsp_valid, pend_q != 3'd0, "result word without a request")
	`R2B_ASSERT_IMP(a_bounded, req_take, pend_q < 3'd3, "request taken with the pipeline full")
	`R2B_ASSERT_IMP(a_plain_zero, plain_word, plain_zero, "status word carries pixel fields")

endmodule

bind raster_to_block_tiler_with_edge_padding_unit r2b_checker u_r2b_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data(rsp.data)
);

`default_nettype wire
